// ===== rtl/oli_pkg.sv =====
// Shared types and constants for the ordered list insert/delete unit.
// Used by the control block, the list cells, the top level and the checker.
// No dependencies.
package oli_pkg;

    // Field widths
    localparam int VALUE_W   = 64;
    localparam int POS_W     = 8;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int CAP_W     = 7;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef logic [VALUE_W-1:0] entry_t;

    // Operation codes carried in s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_GET    = 2'd2
    } kind_t;

    // Result status carried in m_tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_ZERO  = 2'd3
    } status_t;

    // Command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_LOAD   = 3'd3,
        CELL_SHIFT  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
        entry_t             value;
    } cell_cmd_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_SCAN = 1'b1
    } ctl_state_t;

endpackage

// ===== rtl/ordered_list_insert_delete_unit.sv =====
// Ordered list unit: insert, delete and get at a position over a row of cells.
// Insert, delete and refused requests give their result in the cycle after acceptance; a get
// at position p loads the read taps, shifts them one cell a cycle to cell 0, then registers the value there.
// One insert or delete per cycle while the result slot is free; a get holds the input until its result is loaded.
// Reset (aresetn low, synchronous): list empty, capacity limit 64, no result pending.
// Depends on oli_pkg, oli_ctrl and oli_cell.
module ordered_list_insert_delete_unit #(
    parameter int DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [oli_pkg::S_TDATA_W-1:0] s_tdata,  // position[7:0], value[71:8]
    input  logic [oli_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oli_pkg::M_TDATA_W-1:0] m_tdata,  // read_value[63:0], entry_count[70:64]
    output logic [oli_pkg::STATUS_W-1:0]  m_tuser,  // status[1:0]
    input  logic                          cfg_wr_en,
    input  logic [oli_pkg::CAP_W-1:0]     cfg_wr_data
);
    import oli_pkg::*;

    cell_cmd_t cmd;
    entry_t    entry_w [DEPTH];
    entry_t    tap_w   [DEPTH];

    // Sequencer and result register
    oli_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_o       (cmd),
        .tap0_i      (tap_w[0])
    );

    // Row of cells, index 0 at the head of the list
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t left_e, right_e, right_t;
        if (i == 0) begin : g_head
            assign left_e = '0;
        end else begin : g_mid_l
            assign left_e = entry_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_e = entry_w[i];
            assign right_t = '0;
        end else begin : g_mid_r
            assign right_e = entry_w[i+1];
            assign right_t = tap_w[i+1];
        end
        oli_cell #(.IDX(i)) u_cell (
            .aclk          (aclk),
            .cmd_i         (cmd),
            .left_entry_i  (left_e),
            .right_entry_i (right_e),
            .right_tap_i   (right_t),
            .entry_o       (entry_w[i]),
            .tap_o         (tap_w[i])
        );
    end

endmodule

// ===== rtl/oli_cell.sv =====
// One list cell: holds one entry and one read tap, trades data with its neighbors.
// Depends on oli_pkg.
module oli_cell #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  oli_pkg::cell_cmd_t cmd_i,
    input  oli_pkg::entry_t   left_entry_i,
    input  oli_pkg::entry_t   right_entry_i,
    input  oli_pkg::entry_t   right_tap_i,
    output oli_pkg::entry_t   entry_o,
    output oli_pkg::entry_t   tap_o
);
    import oli_pkg::*;

    localparam logic [31:0] CELL_IDX = 32'(IDX);

    entry_t entry_reg, entry_next;
    entry_t tap_reg, tap_next;
    logic   at_pos, past_pos;

    // Locate this cell relative to the requested position
    assign at_pos   = (32'(cmd_i.pos) == CELL_IDX);
    assign past_pos = (32'(cmd_i.pos) < CELL_IDX);

    // Shift entries up on insert, down on delete; load or advance the read tap
    always_comb begin
        entry_next = entry_reg;
        tap_next   = tap_reg;
        case (cmd_i.op)
            CELL_INSERT: begin
                if (at_pos) begin
                    entry_next = cmd_i.value;
                end else if (past_pos) begin
                    entry_next = left_entry_i;
                end
            end
            CELL_DELETE: begin
                if (at_pos || past_pos) begin
                    entry_next = right_entry_i;
                end
            end
            CELL_LOAD:  tap_next = entry_reg;
            CELL_SHIFT: tap_next = right_tap_i;
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry_o = entry_reg;
    assign tap_o   = tap_reg;

endmodule

// ===== rtl/oli_ctrl.sv =====
// Control for the ordered list: handshakes, capacity register, entry count,
// get scan sequencer and the result register. Depends on oli_pkg.
module oli_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [oli_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [oli_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oli_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [oli_pkg::STATUS_W-1:0]  m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [oli_pkg::CAP_W-1:0]     cfg_wr_data,
    output oli_pkg::cell_cmd_t            cmd_o,
    input  oli_pkg::entry_t               tap0_i
);
    import oli_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int W1    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WIDE  = (W1 > COUNT_W) ? W1 : COUNT_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    ctl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, res_status;
    entry_t            out_rd_reg, res_rd;
    logic [COUNT_W-1:0] out_count_reg;
    logic              load_out, out_free, accept;
    logic [POS_W-1:0]  pos;
    entry_t            value;
    kind_t             kind;
    logic [WIDE-1:0]   pos_wide, cnt_wide, cap_wide, cnt_next_wide;
    logic              full, out_of_range;
    logic [POS_W-1:0]  ins_pos;

    // Unpack the request
    assign pos   = s_tdata[POS_W-1:0];
    assign value = s_tdata[POS_W +: VALUE_W];
    assign kind  = kind_t'(s_tuser);

    assign pos_wide      = WIDE'(pos);
    assign cnt_wide      = WIDE'(count_reg);
    assign cap_wide      = WIDE'(cap_reg);
    assign cnt_next_wide = WIDE'(count_next);

    assign full         = (cnt_wide >= cap_wide) || (count_reg >= DEPTH_CNT);
    assign out_of_range = (pos_wide >= cnt_wide);
    // Past the end: append at the current count (then count < 256)
    assign ins_pos      = (pos_wide > cnt_wide) ? cnt_wide[POS_W-1:0] : pos;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == CTL_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Decode requests, drive the cells and sequence a get scan
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        load_out    = 1'b0;
        res_status  = STAT_OK;
        res_rd      = '0;
        cmd_o.op    = CELL_HOLD;
        cmd_o.pos   = pos;
        cmd_o.value = value;
        case (state_reg)
            CTL_IDLE: begin
                if (accept) begin
                    case (kind)
                        KIND_INSERT: begin
                            load_out = 1'b1;
                            if (value == '0) begin
                                res_status = STAT_ZERO;
                            end else if (full) begin
                                res_status = STAT_FULL;
                            end else begin
                                cmd_o.op   = CELL_INSERT;
                                cmd_o.pos  = ins_pos;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_DELETE: begin
                            load_out = 1'b1;
                            if (out_of_range) begin
                                res_status = STAT_RANGE;
                            end else begin
                                cmd_o.op   = CELL_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_GET: begin
                            if (out_of_range) begin
                                load_out   = 1'b1;
                                res_status = STAT_RANGE;
                            end else begin
                                cmd_o.op   = CELL_LOAD;
                                scan_next  = pos_wide[IDX_W-1:0];
                                state_next = CTL_SCAN;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            CTL_SCAN: begin
                if (scan_reg == '0) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        res_rd     = tap0_i;
                        state_next = CTL_IDLE;
                    end
                end else begin
                    cmd_o.op  = CELL_SHIFT;
                    scan_next = scan_reg - 1'b1;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop once taken
    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CTL_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_status_reg <= res_status;
            out_rd_reg     <= res_rd;
            out_count_reg  <= cnt_next_wide[COUNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W - VALUE_W){1'b0}}, out_count_reg, out_rd_reg};

endmodule

// ===== rtl/oli_checker.sv =====
// Port-level checker for the ordered list unit, bound to the top level.
// Depends on oli_pkg and ordered_list_insert_delete_unit.
module oli_checker #(
    parameter int DEPTH = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [oli_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [oli_pkg::STATUS_W-1:0]  m_tuser
);
    import oli_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Accept a request only when the result slot can take its answer
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("request accepted with result slot blocked");

    // Drop the read value on every refused request
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tdata[VALUE_W-1:0] == '0)
        else $error("refused request returned data");

    // Keep the count within the list depth (checked for depths up to 127)
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (DEPTH > 127) || (32'(m_tdata[VALUE_W +: COUNT_W]) <= 32'(DEPTH)))
        else $error("entry count beyond depth");

    // Clear the result after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ordered_list_insert_delete_unit oli_checker #(.DEPTH(DEPTH)) u_oli_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
